// ===== rtl/crcsig_pkg.sv =====
`default_nettype none
package crcsig_pkg;

    // CRC-32 (reflected) constants
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_XOROUT = 32'hFFFF_FFFF;

    // Little-endian signature word and the number of bytes zeroed after it
    localparam logic [31:0] SIG_WORD   = 32'hBADF_00D5;
    localparam logic [2:0]  MASK_BYTES = 3'd4;

    // Defaults for the top-level parameters
    localparam int unsigned COUNT_BITS_DEF  = 32;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // One classified byte travelling from the front end to the CRC engine
    typedef struct packed {
        logic [7:0]  crc_byte;      // byte as it enters the CRC (zero while masked)
        logic        last;          // end of stream
        logic        found;         // signature seen in this stream (valid on last)
        logic [31:0] offset;        // signature start offset, zero if not found
    } t_queue_item;

    // One byte step of the reflected CRC-32
    function automatic logic [31:0] crc_update(input logic [31:0] crc,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = {24'd0, crc[7:0] ^ data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c ^ (crc >> 8);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/crcsig_ifs.sv =====
`default_nettype none
// Byte stream channel
interface crcsig_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result channel
interface crcsig_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] crc_value;
    logic        signature_found;
    logic [31:0] signature_offset;

    modport source (output valid, output crc_value, output signature_found,
                    output signature_offset, input ready);
    modport sink   (input valid, input crc_value, input signature_found,
                    input signature_offset, output ready);
endinterface

// Configuration write channel
interface crcsig_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] search_region_length;

    modport source (output valid, output search_region_length, input ready);
    modport sink   (input valid, input search_region_length, output ready);
endinterface
`default_nettype wire

// ===== rtl/crc32_with_signature_field_masking_unit.sv =====
`default_nettype none
// CRC-32 (reflected, IEEE 802.3) over a byte stream with signature masking.
//
// i_byte   : byte stream (data_byte, last_byte), one byte per transfer.
// o_result : one result per stream (crc_value, signature_found,
//            signature_offset), sent after the byte marked last.
// i_cfg    : write of search_region_length; always ready. Write it only
//            while no stream is in flight.
//
// A front end tracks the byte window and offset, finds the first signature
// word 0xBADF00D5 in the region and zeroes the four bytes after it; a small
// queue carries the classified bytes to the CRC engine.
// Throughput: one byte per cycle while the queue has room, set by the single-byte CRC update.
// With the queue empty, the last byte is written into the queue and then
// moves from the queue head into the registered result slot.
// Reset clears the region length to zero, empties the queue and starts a
// fresh stream. When the result sink stalls, the result is held; bytes keep
// moving until the next last byte reaches the queue head, then they collect
// in the queue (QUEUE_DEPTH entries) and i_byte.ready drops.
module crc32_with_signature_field_masking_unit #(
    parameter int unsigned COUNT_BITS  = crcsig_pkg::COUNT_BITS_DEF,
    parameter int unsigned QUEUE_DEPTH = crcsig_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    crcsig_cfg_if.sink       i_cfg,
    crcsig_byte_if.sink      i_byte,
    crcsig_result_if.source  o_result
);
    import crcsig_pkg::*;

    logic [31:0]  r_region_len;
    logic         push;
    t_queue_item  push_item;
    logic         queue_full;
    logic         head_valid;
    t_queue_item  head_item;
    logic         pop;

    // Configuration register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_len <= '0;
        end else if (i_cfg.valid) begin
            r_region_len <= i_cfg.search_region_length;
        end
    end

    crcsig_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_region_len (r_region_len),
        .i_byte       (i_byte),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_item       (push_item)
    );

    crcsig_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (queue_full),
        .o_valid (head_valid),
        .o_head  (head_item),
        .i_pop   (pop)
    );

    crcsig_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (head_valid),
        .i_head   (head_item),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

// ===== rtl/crcsig_front.sv =====
`default_nettype none
module crcsig_front #(
    parameter int unsigned COUNT_BITS = crcsig_pkg::COUNT_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [31:0]             i_region_len,
    crcsig_byte_if.sink                  i_byte,
    input  wire logic                    i_queue_full,
    output logic                         o_push,
    output crcsig_pkg::t_queue_item      o_item
);
    import crcsig_pkg::*;

    localparam int unsigned CMP_W = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;

    logic [23:0]           r_recent;
    logic [COUNT_BITS-1:0] r_pos;
    logic                  r_found;
    logic [31:0]           r_offset;
    logic [2:0]            r_mask_cnt;

    logic [31:0]           window;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      start;
    logic                  in_region;
    logic                  match;
    logic                  accept;

    // Accept while the queue has room
    assign i_byte.ready = !i_queue_full;
    assign accept       = i_byte.valid && !i_queue_full;

    // Four-byte window, newest byte on top
    assign window    = {i_byte.data_byte, r_recent};
    assign pos_ext   = CMP_W'(r_pos);
    assign start     = pos_ext - CMP_W'(3);
    assign in_region = (pos_ext + CMP_W'(5)) <= CMP_W'(i_region_len);
    assign match     = !r_found && (r_pos >= COUNT_BITS'(3)) && (r_pos != '1)
                       && (window == SIG_WORD) && in_region;

    // Classify the byte for the CRC engine
    always_comb begin
        o_push          = accept;
        o_item.crc_byte = (r_mask_cnt != 3'd0) ? 8'd0 : i_byte.data_byte;
        o_item.last     = i_byte.last_byte;
        o_item.found    = r_found || match;
        o_item.offset   = r_found ? r_offset : (match ? start[31:0] : 32'd0);
    end

    // Track position, window and match state; clear at end of stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent   <= '0;
            r_pos      <= '0;
            r_found    <= 1'b0;
            r_offset   <= '0;
            r_mask_cnt <= '0;
        end else if (accept) begin
            if (i_byte.last_byte) begin
                r_recent   <= '0;
                r_pos      <= '0;
                r_found    <= 1'b0;
                r_offset   <= '0;
                r_mask_cnt <= '0;
            end else begin
                r_recent <= window[31:8];
                if (r_pos != '1) begin
                    r_pos <= r_pos + COUNT_BITS'(1);
                end
                if (match) begin
                    r_found    <= 1'b1;
                    r_offset   <= start[31:0];
                    r_mask_cnt <= MASK_BYTES;
                end else if (r_mask_cnt != 3'd0) begin
                    r_mask_cnt <= r_mask_cnt - 3'd1;
                end
            end
        end
    end

    a_mask_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mask_cnt != 3'd0) |-> r_found)
        else $error("masking active without a signature");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_byte.last_byte) |=> (r_pos == '0 && !r_found))
        else $error("stream state not cleared after last byte");

    a_found_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && !(accept && i_byte.last_byte)) |=> (r_found && $stable(r_offset)))
        else $error("signature offset changed within a stream");

endmodule
`default_nettype wire

// ===== rtl/crcsig_queue.sv =====
`default_nettype none
module crcsig_queue #(
    parameter int unsigned DEPTH = crcsig_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_push,
    input  crcsig_pkg::t_queue_item      i_item,
    output logic                         o_full,
    output logic                         o_valid,
    output crcsig_pkg::t_queue_item      o_head,
    input  wire logic                    i_pop
);
    import crcsig_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_queue_item        r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue occupancy beyond depth");

endmodule
`default_nettype wire

// ===== rtl/crcsig_back.sv =====
`default_nettype none
module crcsig_back (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  crcsig_pkg::t_queue_item      i_head,
    output logic                         o_pop,
    crcsig_result_if.source              o_result
);
    import crcsig_pkg::*;

    logic [31:0] r_crc;
    logic        r_out_valid;
    logic [31:0] r_out_crc;
    logic        r_out_found;
    logic [31:0] r_out_offset;
    logic [31:0] n_crc;
    logic        out_free;

    assign out_free = !r_out_valid || o_result.ready;
    // A last byte needs the result slot; other bytes always move
    assign o_pop    = i_valid && (!i_head.last || out_free);
    assign n_crc    = crc_update(r_crc, i_head.crc_byte);

    assign o_result.valid            = r_out_valid;
    assign o_result.crc_value        = r_out_crc;
    assign o_result.signature_found  = r_out_found;
    assign o_result.signature_offset = r_out_offset;

    // Run the CRC; restart it after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else if (o_pop) begin
            r_crc <= i_head.last ? CRC_INIT : n_crc;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_head.last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.last) begin
            r_out_crc    <= n_crc ^ CRC_XOROUT;
            r_out_found  <= i_head.found;
            r_out_offset <= i_head.offset;
        end
    end

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.last) |=> r_out_valid)
        else $error("result missing after last byte");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.last) |-> out_free)
        else $error("pending result overwritten");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int unsigned POS_BITS         = crcsig_pkg::COUNT_BITS_DEF;
    localparam logic [31:0] POLY_REFLECTED   = 32'hEDB8_8320;
    localparam logic [31:0] SIGNATURE        = 32'hBADF_00D5;
    localparam logic [2:0]  ZEROED_BYTES     = 3'd4;
    localparam int          RESET_CYCLES     = 11;
    localparam int          DRAIN_CYCLES     = 4;
    localparam int          TAIL_CYCLES      = 10;
    localparam int          PHASE_BYTES      = 106;
    localparam int          PHASE_COUNT      = 8;
    localparam int          LONG_HOLD_AFTER  = 300;
    localparam int          LONG_HOLD_CYCLES = 400;
    localparam int          CYCLE_LIMIT      = 400_000;

    typedef struct packed {
        logic [7:0] value;
        logic       is_last;
    } stream_byte_t;

    typedef struct packed {
        logic [31:0] crc;
        logic        found;
        logic [31:0] offset;
    } stream_summary_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    crcsig_cfg_if    cfg_bus ();
    crcsig_byte_if   byte_bus ();
    crcsig_result_if result_bus ();

    crc32_with_signature_field_masking_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_bus),
        .i_byte   (byte_bus),
        .o_result (result_bus)
    );

    // Stimulus and scoreboard storage
    stream_byte_t    bytes_to_send[$];
    stream_summary_t crc_results_due[$];

    // Mirror of the block: configuration and per-stream state
    logic [31:0]         region_length = 32'd0;
    logic [31:0]         running_crc   = 32'hFFFF_FFFF;
    logic [23:0]         recent_window = 24'd0;
    logic [POS_BITS-1:0] stream_pos    = '0;
    logic                sig_seen      = 1'b0;
    logic [31:0]         sig_offset    = 32'd0;
    logic [2:0]          zero_left     = 3'd0;

    // Handshake flags and counters
    logic byte_fired     = 1'b0;
    logic cfg_fired      = 1'b0;
    logic long_hold_done = 1'b0;
    logic steady_flow    = 1'b0;
    int   send_gap       = 0;
    int   hold_left      = 0;
    int   bytes_in       = 0;
    int   cycle_count    = 0;
    int   fail_count     = 0;

    // Clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Bit-serial reflected CRC-32 update, LSB of the byte first
    function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] value);
        logic [31:0] c;
        logic        feedback;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            feedback = c[0] ^ value[i];
            c = c >> 1;
            if (feedback) c = c ^ POLY_REFLECTED;
        end
        return c;
    endfunction

    // Advance the stream mirror by one byte; queue a summary on the last byte
    function automatic void predict_byte(input logic [7:0] value, input logic is_last);
        logic [31:0]     window_word;
        longint unsigned sig_start;
        stream_summary_t summary;
        window_word = {value, recent_window};
        if (zero_left != 3'd0) begin
            running_crc = crc32_step(running_crc, 8'h00);
            zero_left = zero_left - 3'd1;
        end else begin
            running_crc = crc32_step(running_crc, value);
        end
        // A match needs a full window and a known (unsaturated) position
        if (!sig_seen && stream_pos >= 3 && stream_pos != '1 && window_word == SIGNATURE) begin
            sig_start = 64'(stream_pos) - 64'd3;
            if (sig_start + 64'd8 <= 64'(region_length)) begin
                sig_seen = 1'b1;
                sig_offset = sig_start[31:0];
                zero_left = ZEROED_BYTES;
            end
        end
        recent_window = window_word[31:8];
        if (stream_pos != '1) stream_pos = stream_pos + 1'b1;
        if (is_last) begin
            summary.crc = running_crc ^ 32'hFFFF_FFFF;
            summary.found = sig_seen;
            summary.offset = sig_seen ? sig_offset : 32'd0;
            crc_results_due.push_back(summary);
            running_crc = 32'hFFFF_FFFF;
            recent_window = 24'd0;
            stream_pos = '0;
            sig_seen = 1'b0;
            sig_offset = 32'd0;
            zero_left = 3'd0;
        end
    endfunction

    // Mostly no pause, some short ones, a few long ones
    function automatic int pick_pause();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endtask

    // Sample every handshake at the rising edge
    always @(posedge i_clk) begin
        stream_summary_t due;
        cycle_count <= cycle_count + 1;
        byte_fired  <= i_rst_n && byte_bus.valid && byte_bus.ready;
        cfg_fired   <= i_rst_n && cfg_bus.valid && cfg_bus.ready;
        if (i_rst_n) begin
            if (cfg_bus.valid && cfg_bus.ready)
                region_length <= cfg_bus.search_region_length;
            if (byte_bus.valid && byte_bus.ready) begin
                predict_byte(byte_bus.data_byte, byte_bus.last_byte);
                bytes_in <= bytes_in + 1;
            end
            if (result_bus.valid && result_bus.ready) begin
                if (crc_results_due.size() == 0) begin
                    log_failure($sformatf("unexpected result crc=%h found=%b offset=%h",
                        result_bus.crc_value, result_bus.signature_found,
                        result_bus.signature_offset));
                end else begin
                    due = crc_results_due.pop_front();
                    if (result_bus.crc_value !== due.crc ||
                        result_bus.signature_found !== due.found ||
                        result_bus.signature_offset !== due.offset)
                        log_failure($sformatf(
                            "result mismatch: expected crc=%h found=%b offset=%h, got crc=%h found=%b offset=%h",
                            due.crc, due.found, due.offset, result_bus.crc_value,
                            result_bus.signature_found, result_bus.signature_offset));
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Byte sender: hold the byte until its transfer, then pause or advance
    always @(negedge i_clk) begin
        stream_byte_t next_item;
        if (!byte_bus.valid || byte_fired) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                byte_bus.valid <= 1'b0;
            end else if (bytes_to_send.size() != 0) begin
                next_item = bytes_to_send.pop_front();
                byte_bus.valid     <= 1'b1;
                byte_bus.data_byte <= next_item.value;
                byte_bus.last_byte <= next_item.is_last;
                send_gap <= pick_pause();
            end else begin
                byte_bus.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off to fill the block
    always @(negedge i_clk) begin
        int n;
        if (!long_hold_done && bytes_in >= LONG_HOLD_AFTER) begin
            long_hold_done <= 1'b1;
            hold_left <= LONG_HOLD_CYCLES;
            result_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            result_bus.ready <= 1'b0;
        end else begin
            n = pick_pause();
            if (n > 0) begin
                hold_left <= n - 1;
                result_bus.ready <= 1'b0;
            end else begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    task automatic queue_stream(input logic [7:0] content[$]);
        stream_byte_t item;
        foreach (content[k]) begin
            item.value = content[k];
            item.is_last = (k == content.size() - 1);
            bytes_to_send.push_back(item);
        end
    endtask

    // Write the signature word little-endian; bytes past the end are dropped
    task automatic plant_signature(inout logic [7:0] content[$], input int at);
        for (int b = 0; b < 4; b++)
            if (at + b < content.size()) content[at + b] = SIGNATURE[8*b +: 8];
    endtask

    // Random stream: mostly planted signatures, some near misses, some noise
    task automatic queue_random_stream(output int len);
        logic [7:0] content[$];
        int         style;
        int         at;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 80) : $urandom_range(1, 32);
        for (int k = 0; k < len; k++) content.push_back(8'($urandom_range(0, 255)));
        style = $urandom_range(0, 99);
        at = $urandom_range(0, len - 1);
        if (style < 60) begin
            plant_signature(content, at);
        end else if (style < 75) begin
            // three bytes right, the fourth off by one bit
            plant_signature(content, at);
            if (at + 3 < len) content[at + 3] = content[at + 3] ^ (8'h01 << $urandom_range(0, 7));
        end else if (style < 85) begin
            plant_signature(content, at);
            plant_signature(content, $urandom_range(0, len - 1));
        end
        queue_stream(content);
    endtask

    // Hold until nothing is in flight, then let the pipeline settle
    task automatic wait_until_drained();
        while (bytes_to_send.size() != 0 || byte_bus.valid || crc_results_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_region(input logic [31:0] len);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.search_region_length <= len;
        @(negedge i_clk);
        while (!cfg_fired) @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    initial begin
        int phase_bytes;
        int len;
        logic [31:0] region;
        i_rst_n = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.search_region_length = 32'd0;
        byte_bus.valid = 1'b0;
        byte_bus.data_byte = 8'd0;
        byte_bus.last_byte = 1'b0;
        result_bus.ready = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: one-byte streams under the reset region (no search possible)
        queue_stream('{8'h00});
        queue_stream('{8'hFF});
        wait_until_drained();

        // Region of nine bytes: start offsets 0 and 1 qualify, 2 does not
        write_region(32'd9);
        // match at the very start, masked field, then a second word that is ignored
        queue_stream('{8'hD5, 8'h00, 8'hDF, 8'hBA, 8'h80, 8'hFF, 8'h7F, 8'h01,
                       8'hD5, 8'h00, 8'hDF, 8'hBA});
        // match at the region boundary, stream ends while still masking
        queue_stream('{8'h00, 8'hD5, 8'h00, 8'hDF, 8'hBA, 8'hFF});
        // one byte past the boundary: not accepted
        queue_stream('{8'h00, 8'h00, 8'hD5, 8'h00, 8'hDF, 8'hBA});
        wait_until_drained();

        // Random phases, each under its own region length
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: region = 32'd0;
                1: region = 32'd7;
                2: region = 32'd8;
                3: region = $urandom_range(9, 48);
                4: region = 32'hFFFF_FFFF;
                5: region = 32'd16;
                6: region = $urandom;
                default: region = 32'd24;
            endcase
            steady_flow = (p == 3 || p == 6);
            write_region(region);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                queue_random_stream(len);
                phase_bytes += len;
            end
            wait_until_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        while (crc_results_due.size() != 0) begin
            void'(crc_results_due.pop_front());
            log_failure("expected result never arrived");
        end
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
